@@ rtl/core/bdhd_pkg.sv @@
package bdhd_pkg;

    // Number of button lanes; the mask fields are this wide
    localparam int NUM_BUTTONS = 5;

    localparam int CNT_W  = 4;
    localparam int HOLD_W = 16;
    localparam int QRY_W  = 3;
    localparam int IDX_W  = 1;
    localparam int CFG_W  = 16;

    // Hold timer saturation value
    localparam logic [HOLD_W-1:0] HOLD_SAT = 16'hFFFF;

    // Reset values of the configuration registers
    localparam logic [CNT_W-1:0]  DEBOUNCE_LIMIT_RST = 4'd5;
    localparam logic [HOLD_W-1:0] HOLD_LIMIT_RST     = 16'd1000;

    // Operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 1'd0;
    localparam logic [IDX_W-1:0] CFG_HOLD_LIMIT     = 1'd1;

    typedef struct packed {
        logic                   operation;
        logic [NUM_BUTTONS-1:0] raw_buttons;
        logic [QRY_W-1:0]       query_button;
    } in_item_t;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] down_mask;
        logic [NUM_BUTTONS-1:0] frame_pressed;
        logic [NUM_BUTTONS-1:0] frame_held;
        logic                   new_press;
        logic [HOLD_W-1:0]      held_time;
    } out_item_t;

    // Shared control fed to every button lane
    typedef struct packed {
        logic              upd;        // commit a tick this cycle
        logic [CNT_W-1:0]  lim;        // effective debounce limit, never zero
        logic [HOLD_W-1:0] hold_limit;
    } lane_ctrl_t;

    // Per-lane status, values after the item being committed
    typedef struct packed {
        logic              stable;
        logic              rise;
        logic              hold_fire;
        logic [HOLD_W-1:0] hold_ticks;
    } lane_status_t;

endpackage

@@ rtl/core/button_debounce_hold_detector_unit.sv @@
// Button debouncer with press and long-press detection for five active-high
// buttons. Each input item is either a tick (raw button levels) or a frame
// snapshot, and produces exactly one result item. One item is taken per
// clock while the result side does not stall. An item is registered in the
// input register when accepted, and its result in the result register once
// that register is free or being taken; while a result waits to be taken,
// one more item can sit in the input register. The user writes the debounce
// and hold limits through cfg_wr_en / cfg_index / cfg_wdata (index 0 =
// debounce_limit, index 1 = hold_limit) only while no item is in flight;
// the block does not enforce this. A debounce limit of 0 acts as 1.
module button_debounce_hold_detector_unit (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_wr_en,
    input  logic [bdhd_pkg::IDX_W-1:0]       cfg_index,
    input  logic [bdhd_pkg::CFG_W-1:0]       cfg_wdata,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  bdhd_pkg::in_item_t               in_data,

    output logic                             out_valid,
    input  logic                             out_ready,
    output bdhd_pkg::out_item_t              out_data
);

    localparam int NB = bdhd_pkg::NUM_BUTTONS;

    logic [bdhd_pkg::CNT_W-1:0]  debounce_limit_reg;
    logic [bdhd_pkg::HOLD_W-1:0] hold_limit_reg;

    logic                        s1_valid_reg;
    bdhd_pkg::in_item_t          s1_reg;
    logic                        out_valid_reg;
    bdhd_pkg::out_item_t         out_reg, out_next;

    logic [NB-1:0]               pending_press_reg, pending_press_next;
    logic [NB-1:0]               pending_hold_reg, pending_hold_next;
    logic [NB-1:0]               snap_press_reg, snap_press_next;
    logic [NB-1:0]               snap_hold_reg, snap_hold_next;

    logic                        adv;
    bdhd_pkg::lane_ctrl_t        ctrl;
    bdhd_pkg::lane_status_t      stat [NB];
    logic [NB-1:0]               stable_m, rise_m, fire_m;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_limit_reg <= bdhd_pkg::DEBOUNCE_LIMIT_RST;
            hold_limit_reg     <= bdhd_pkg::HOLD_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bdhd_pkg::CFG_DEBOUNCE_LIMIT:
                    debounce_limit_reg <= cfg_wdata[bdhd_pkg::CNT_W-1:0];
                bdhd_pkg::CFG_HOLD_LIMIT:
                    hold_limit_reg <= cfg_wdata[bdhd_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow: stage 1 moves to the result register when it is free
    assign adv      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_reg <= in_data;
        if (adv)
            out_reg <= out_next;
    end

    // Lane control
    assign ctrl.upd        = adv && (s1_reg.operation == bdhd_pkg::OP_TICK);
    assign ctrl.lim        = (debounce_limit_reg == '0) ? 4'd1 : debounce_limit_reg;
    assign ctrl.hold_limit = hold_limit_reg;

    // Per-button integrator and hold timer
    for (genvar i = 0; i < NB; i++)
    begin : g_lane
        bdhd_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .raw    (s1_reg.raw_buttons[i]),
            .status (stat[i])
        );
        assign stable_m[i] = stat[i].stable;
        assign rise_m[i]   = stat[i].rise;
        assign fire_m[i]   = stat[i].hold_fire;
    end

    // Event accumulators and frame snapshot
    always_comb
    begin
        pending_press_next = pending_press_reg | rise_m;
        pending_hold_next  = pending_hold_reg | fire_m;
        snap_press_next    = snap_press_reg;
        snap_hold_next     = snap_hold_reg;
        if (s1_reg.operation == bdhd_pkg::OP_FRAME)
        begin
            snap_press_next    = pending_press_reg;
            snap_hold_next     = pending_hold_reg;
            pending_press_next = '0;
            pending_hold_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_press_reg <= '0;
            pending_hold_reg  <= '0;
            snap_press_reg    <= '0;
            snap_hold_reg     <= '0;
        end
        else if (adv)
        begin
            pending_press_reg <= pending_press_next;
            pending_hold_reg  <= pending_hold_next;
            snap_press_reg    <= snap_press_next;
            snap_hold_reg     <= snap_hold_next;
        end
    end

    // Result assembly
    always_comb
    begin
        out_next               = '0;
        out_next.down_mask     = stable_m;
        out_next.frame_pressed = snap_press_next;
        out_next.frame_held    = snap_hold_next;
        out_next.new_press     = |rise_m;
        if (s1_reg.query_button < bdhd_pkg::QRY_W'(NB))
            out_next.held_time = stat[s1_reg.query_button].hold_ticks;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A new press always shows a button down in the same result
    a_press_down: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.new_press) |-> (out_data.down_mask != '0))
        else $error("new_press without any button down");

    // A frame snapshot empties both accumulators
    a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_reg.operation == bdhd_pkg::OP_FRAME)
        |=> (pending_press_reg == '0 && pending_hold_reg == '0))
        else $error("accumulators not cleared by frame snapshot");

    // Snapshot items report no press (they cause no lane update)
    a_frame_no_press: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_reg.operation == bdhd_pkg::OP_FRAME) |=> !out_reg.new_press)
        else $error("new_press set on a frame snapshot");

endmodule

@@ rtl/core/bdhd_lane.sv @@
module bdhd_lane (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bdhd_pkg::lane_ctrl_t    ctrl,
    input  logic                    raw,
    output bdhd_pkg::lane_status_t  status
);

    logic [bdhd_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        stable_reg, stable_next;
    logic [bdhd_pkg::HOLD_W-1:0] hold_reg, hold_next, hold_inc;
    logic                        fired_reg, fired_next;
    logic                        fire;

    // Up/down integrator, saturating at 0 and at the limit
    always_comb
    begin
        cnt_next = cnt_reg;
        if (raw)
        begin
            if (cnt_reg < ctrl.lim)
                cnt_next = cnt_reg + 4'd1;
        end
        else
        begin
            if (cnt_reg != '0)
                cnt_next = cnt_reg - 4'd1;
        end
    end

    // Stable state: down at limit, up at zero, else keep
    always_comb
    begin
        if (cnt_next == ctrl.lim)
            stable_next = 1'b1;
        else if (cnt_next != '0)
            stable_next = stable_reg;
        else
            stable_next = 1'b0;
    end

    // Hold timer and one-shot hold event
    always_comb
    begin
        hold_inc   = (hold_reg < bdhd_pkg::HOLD_SAT) ? hold_reg + 16'd1 : hold_reg;
        fire       = 1'b0;
        hold_next  = '0;
        fired_next = 1'b0;
        if (stable_next)
        begin
            hold_next  = hold_inc;
            fire       = (hold_inc >= ctrl.hold_limit) && !fired_reg;
            fired_next = fired_reg | fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            stable_reg <= 1'b0;
            hold_reg   <= '0;
            fired_reg  <= 1'b0;
        end
        else if (ctrl.upd)
        begin
            cnt_reg    <= cnt_next;
            stable_reg <= stable_next;
            hold_reg   <= hold_next;
            fired_reg  <= fired_next;
        end
    end

    // Values as seen after this item
    assign status.stable     = ctrl.upd ? stable_next : stable_reg;
    assign status.rise       = ctrl.upd & stable_next & ~stable_reg;
    assign status.hold_fire  = ctrl.upd & fire;
    assign status.hold_ticks = ctrl.upd ? hold_next : hold_reg;

endmodule

@@ dv/button_debounce_hold_checker.sv @@
module button_debounce_hold_checker
    import bdhd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_wr_en,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,

    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_item_t             in_data,

    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_item_t            out_data,

    output int                   fail_count,
    output int                   outstanding,
    output int                   checked_count,
    output int                   press_events,
    output int                   hold_events
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the limits
    logic [CNT_W-1:0]       deb_lim;
    logic [HOLD_W-1:0]      hold_lim;

    // Shadow copy of the button state
    logic [CNT_W-1:0]       settle [NUM_BUTTONS];
    logic [HOLD_W-1:0]      hold_cnt [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] stable;
    logic [NUM_BUTTONS-1:0] fired;
    logic [NUM_BUTTONS-1:0] pend_press;
    logic [NUM_BUTTONS-1:0] pend_hold;
    logic [NUM_BUTTONS-1:0] snap_press;
    logic [NUM_BUTTONS-1:0] snap_hold;

    out_item_t              expected_reports [$];
    out_item_t              predicted;
    out_item_t              oldest;

    task automatic report_mismatch(input string msg);
        $display("ERROR: result %0d: %s", checked_count, msg);
        fail_count++;
    endtask

    // Advance the button state by one item and build the report it causes
    task automatic step_buttons(input in_item_t item, output out_item_t rep);
        logic [CNT_W-1:0]       lim;
        logic [NUM_BUTTONS-1:0] nxt;
        logic [NUM_BUTTONS-1:0] rise;
        lim  = (deb_lim == '0) ? CNT_W'(1) : deb_lim;
        nxt  = '0;
        rise = '0;
        if (item.operation == OP_TICK)
        begin
            // integrator step and stable-state decision
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                if (item.raw_buttons[b])
                begin
                    if (settle[b] < lim)
                        settle[b] = settle[b] + 1'b1;
                end
                else if (settle[b] != '0)
                begin
                    settle[b] = settle[b] - 1'b1;
                end
                if (settle[b] == lim)
                    nxt[b] = 1'b1;
                else if (settle[b] != '0)
                    nxt[b] = stable[b];
            end
            rise = nxt & ~stable;
            // hold timers, one-shot held event
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                if (nxt[b])
                begin
                    if (hold_cnt[b] != HOLD_SAT)
                        hold_cnt[b] = hold_cnt[b] + 1'b1;
                    if (hold_cnt[b] >= hold_lim && !fired[b])
                    begin
                        pend_hold[b] = 1'b1;
                        fired[b]     = 1'b1;
                        hold_events++;
                    end
                end
                else
                begin
                    hold_cnt[b] = '0;
                    fired[b]    = 1'b0;
                end
            end
            pend_press   = pend_press | rise;
            stable       = nxt;
            press_events += $countones(rise);
        end
        else
        begin
            // frame snapshot
            snap_press = pend_press;
            snap_hold  = pend_hold;
            pend_press = '0;
            pend_hold  = '0;
        end
        rep.down_mask     = stable;
        rep.frame_pressed = snap_press;
        rep.frame_held    = snap_hold;
        rep.new_press     = (rise != '0);
        rep.held_time     = (item.query_button < NUM_BUTTONS) ?
                            hold_cnt[item.query_button] : '0;
    endtask

    task automatic compare_report(input out_item_t want, input out_item_t got);
        if (got.down_mask !== want.down_mask)
            report_mismatch($sformatf("down_mask exp %b got %b",
                                      want.down_mask, got.down_mask));
        if (got.frame_pressed !== want.frame_pressed)
            report_mismatch($sformatf("frame_pressed exp %b got %b",
                                      want.frame_pressed, got.frame_pressed));
        if (got.frame_held !== want.frame_held)
            report_mismatch($sformatf("frame_held exp %b got %b",
                                      want.frame_held, got.frame_held));
        if (got.new_press !== want.new_press)
            report_mismatch($sformatf("new_press exp %b got %b",
                                      want.new_press, got.new_press));
        if (got.held_time !== want.held_time)
            report_mismatch($sformatf("held_time exp %0d got %0d",
                                      want.held_time, got.held_time));
    endtask

    // Watch config writes, accepted items and accepted results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_lim    = DEBOUNCE_LIMIT_RST;
            hold_lim   = HOLD_LIMIT_RST;
            stable     = '0;
            fired      = '0;
            pend_press = '0;
            pend_hold  = '0;
            snap_press = '0;
            snap_hold  = '0;
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                settle[b]   = '0;
                hold_cnt[b] = '0;
            end
            expected_reports.delete();
            fail_count    = 0;
            outstanding   = 0;
            checked_count = 0;
            press_events  = 0;
            hold_events   = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE_LIMIT: deb_lim  = cfg_wdata[CNT_W-1:0];
                    CFG_HOLD_LIMIT:     hold_lim = cfg_wdata[HOLD_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                step_buttons(in_data, predicted);
                expected_reports.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    report_mismatch("result with no item waiting");
                end
                else
                begin
                    oldest = expected_reports.pop_front();
                    compare_report(oldest, out_data);
                end
                checked_count++;
            end
            outstanding = expected_reports.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bdhd_pkg::*;

    localparam int STUCK_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 225;
    localparam int NUM_PHASES   = 8;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;

    int                   fail_count;
    int                   outstanding;
    int                   checked_count;
    int                   press_events;
    int                   hold_events;

    int                   n_sent;
    int                   n_recv;
    int                   gap_max;
    int                   rx_wait;
    int                   stuck_cycles;

    // Intended button levels and tick items left before each one toggles
    logic [NUM_BUTTONS-1:0] intent;
    int                     dwell [NUM_BUTTONS];

    // Limits swept by the random phases, extremes included
    int deb_sweep  [NUM_PHASES] = '{3, 15, 1, 0, 7, 2, 15, 4};
    int hold_sweep [NUM_PHASES] = '{12, 40, 1, 0, 150, 25, 65535, 6};

    button_debounce_hold_detector_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    button_debounce_hold_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count),
        .press_events  (press_events),
        .hold_events   (hold_events)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stall after every accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            n_recv++;
            rx_wait = $urandom_range(0, gap_max);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_wait > 0)
            begin
                out_ready <= 1'b0;
                rx_wait = rx_wait - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Count cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("ERROR: no handshake for %0d cycles", STUCK_LIMIT);
        $display("FAIL");
        $finish;
    end

    function automatic in_item_t make_item(input logic op, input logic [NUM_BUTTONS-1:0] raw,
                                           input logic [QRY_W-1:0] q);
        in_item_t item;
        item.operation    = op;
        item.raw_buttons  = raw;
        item.query_button = q;
        return item;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input in_item_t item);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_sent++;
        @(negedge clk);
    endtask

    // Drain, let the pipeline settle, then write both limits
    task automatic write_limits(input logic [CNT_W-1:0] deb, input logic [HOLD_W-1:0] hold);
        in_valid <= 1'b0;
        while (n_recv != n_sent)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DEBOUNCE_LIMIT;
        cfg_wdata <= {(CFG_W-CNT_W)'($urandom), deb};
        @(negedge clk);
        cfg_index <= CFG_HOLD_LIMIT;
        cfg_wdata <= hold;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [QRY_W-1:0] pick_query();
        if ($urandom_range(0, 5) == 0)
            return QRY_W'($urandom_range(NUM_BUTTONS, (1 << QRY_W) - 1));
        return QRY_W'($urandom_range(0, NUM_BUTTONS - 1));
    endfunction

    // Buttons held or released for random stretches, with contact bounce
    task automatic run_phase(input int count, input int dwell_max);
        logic [NUM_BUTTONS-1:0] raw;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                send_item(make_item(OP_FRAME, NUM_BUTTONS'($urandom), pick_query()));
            end
            else
            begin
                for (int b = 0; b < NUM_BUTTONS; b++)
                begin
                    if (dwell[b] == 0)
                    begin
                        intent[b] = ~intent[b];
                        dwell[b]  = $urandom_range(1, dwell_max);
                    end
                    else
                    begin
                        dwell[b]--;
                    end
                end
                raw = intent;
                if ($urandom_range(0, 15) == 0)
                begin
                    raw = NUM_BUTTONS'($urandom);
                end
                else
                begin
                    for (int b = 0; b < NUM_BUTTONS; b++)
                        if ($urandom_range(0, 9) == 0)
                            raw[b] = ~raw[b];
                end
                send_item(make_item(OP_TICK, raw, pick_query()));
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        n_sent    = 0;
        n_recv    = 0;
        rx_wait   = 0;
        gap_max   = 9;
        intent    = '0;
        for (int b = 0; b < NUM_BUTTONS; b++)
            dwell[b] = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: snapshot on empty state, queries past the last button
        send_item(make_item(OP_FRAME, '0, 3'd0));
        send_item(make_item(OP_TICK, '1, 3'd7));
        send_item(make_item(OP_TICK, '0, 3'd5));

        // Debounce limit zero acts as one, hold limit zero fires at once
        write_limits('0, '0);
        send_item(make_item(OP_TICK, 5'b10101, 3'd0));
        send_item(make_item(OP_FRAME, 5'b11111, 3'd2));
        send_item(make_item(OP_TICK, 5'b01010, 3'd1));
        send_item(make_item(OP_FRAME, 5'b00000, 3'd6));
        send_item(make_item(OP_TICK, 5'b00000, 3'd3));

        // Build counters up to six, then lower the limit below them
        write_limits(4'd6, 16'd1);
        for (int n = 0; n < 6; n++)
            send_item(make_item(OP_TICK, '1, QRY_W'(n % NUM_BUTTONS)));
        write_limits(4'd2, 16'd1000);
        send_item(make_item(OP_TICK, '1, 3'd4));
        for (int n = 0; n < 6; n++)
            send_item(make_item(OP_TICK, '0, QRY_W'(n)));
        send_item(make_item(OP_FRAME, '0, 3'd1));

        // Random phases over a sweep of limits, some without idling
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_limits(CNT_W'(deb_sweep[p]), HOLD_W'(hold_sweep[p]));
            gap_max = (p % 3 == 2) ? 0 : 9;
            run_phase(PHASE_ITEMS, (hold_sweep[p] > 150) ? 60 :
                                   2 * hold_sweep[p] + 4 * deb_sweep[p] + 8);
        end

        // Closing snapshot, release, snapshot
        gap_max = 9;
        send_item(make_item(OP_FRAME, '1, 3'd0));
        send_item(make_item(OP_TICK, '0, 3'd4));
        send_item(make_item(OP_FRAME, '0, 3'd2));

        // Drain and let the pipeline go quiet
        in_valid <= 1'b0;
        while (n_recv != n_sent)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Checked %0d results over %0d items, debounce limits 0 to 15,",
                 checked_count, n_sent);
        $display("hold limits 0 to 65535; %0d presses and %0d hold events predicted",
                 press_events, hold_events);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
